>>> src/odo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry package
// Shared types, constants and arithmetic helpers for the differential drive
// odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

    // Opcodes of an input word.
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_DIST      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_HALF_TRACK = 1'b1;
    localparam logic [23:0] INV_HALF_TRACK_RST = 24'd448876;

    // Serial multiplier geometry.
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 33;
    localparam int MUL_N_W = 6;

    // Scale constants.
    localparam logic signed [MUL_B_W-1:0] RAD_TO_TURN = 33'sd683565276;
    localparam logic signed [MUL_B_W-1:0] VEL_SCALE   = 33'sd100;

    // CORDIC constants.
    localparam int ATAN_ENTRIES     = 24;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_IDX_W     = $clog2(ATAN_ENTRIES);
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Input and result words.
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] left_count;
        logic signed [15:0] right_count;
        logic signed [15:0] left_rate;
        logic signed [15:0] right_rate;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic [15:0]        new_yaw;
    } odo_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [31:0] lin_vel;
        logic signed [31:0] rot_vel;
    } odo_out_t;

    // Command to the serial multiplier.
    typedef struct packed {
        logic               start;
        logic [MUL_N_W-1:0] nbits;
    } odo_mul_ctl_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [29:0] atan_val(input logic [CORDIC_IDX_W-1:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Arithmetic right shift that rounds half up.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                      input int s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> src/odo_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry serial multiplier
// Radix-2 shift-and-add multiplier. The multiplier operand is scanned one bit
// per cycle, its top scanned bit carrying negative weight.
// ----------------------------------------------------------------------------
module odo_mul
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  odo_pkg::odo_mul_ctl_t                      ctl,
    input  logic signed [odo_pkg::MUL_A_W-1:0]         a,
    input  logic signed [odo_pkg::MUL_B_W-1:0]         b,
    output logic signed [odo_pkg::MUL_A_W-1:0]         prod,
    output logic                                       done
);

    logic signed [odo_pkg::MUL_A_W-1:0] acc_reg;
    logic signed [odo_pkg::MUL_A_W-1:0] a_reg;
    logic [odo_pkg::MUL_B_W-1:0]        b_reg;
    logic [odo_pkg::MUL_N_W-1:0]        cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic signed [odo_pkg::MUL_A_W-1:0] partial;
    logic                               last;

    // Partial product of the current multiplier bit.
    always_comb
    begin
        partial = b_reg[0] ? a_reg : '0;
        last    = (cnt_reg == odo_pkg::MUL_N_W'(1));
    end

    // Control: count the scanned bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - odo_pkg::MUL_N_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: accumulate shifted multiplicand, sign bit subtracts.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= last ? acc_reg - partial : acc_reg + partial;
            a_reg   <= a_reg <<< 1;
            b_reg   <= b_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

>>> src/odo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry CORDIC
// Iterative rotation-mode CORDIC giving cosine and sine of a 16-bit binary
// angle in Q2.30, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module odo_cordic
#(
    parameter int STEPS = odo_pkg::CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        angle,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val,
    output logic               done
);

    localparam int LIMIT = (STEPS > odo_pkg::ATAN_ENTRIES) ? odo_pkg::ATAN_ENTRIES : STEPS;
    localparam int IW    = odo_pkg::CORDIC_IDX_W;

    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [32:0] z_reg;
    logic [1:0]         quad_reg;
    logic [IW-1:0]      idx_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [32:0] at;
    logic signed [33:0] nx;
    logic signed [33:0] ny;

    // Shifted terms of the current micro-rotation.
    always_comb
    begin
        xs = x_reg >>> idx_reg;
        ys = y_reg >>> idx_reg;
        at = $signed({3'b000, odo_pkg::atan_val(idx_reg)});
        nx = -x_reg;
        ny = -y_reg;
    end

    // Control: iteration count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (idx_reg == IW'(LIMIT - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: rotate toward zero residual angle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= odo_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({3'b000, angle[13:0], 16'h0000});
            quad_reg <= angle[15:14];
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    // Quadrant fold.
    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                cos_val = x_reg[31:0];
                sin_val = y_reg[31:0];
            end
            2'd1:
            begin
                cos_val = ny[31:0];
                sin_val = x_reg[31:0];
            end
            2'd2:
            begin
                cos_val = nx[31:0];
                sin_val = ny[31:0];
            end
            default:
            begin
                cos_val = y_reg[31:0];
                sin_val = nx[31:0];
            end
        endcase
    end

    assign done = done_reg;

endmodule

>>> src/diff_drive_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive odometry
// Dead-reckoning pose tracker for a two-wheeled robot, built around a shared
// bit-serial multiplier and an iterative CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   An input word arrives on in_valid/in_ready/in_data and carries an opcode:
//   tick update, set pose or reset pose. Each word yields one result word on
//   out_valid/out_ready/out_data with the pose and the two velocities.
//   The tick distance and inverse half track registers are written through
//   cfg_wr_en/cfg_index/cfg_data, which the user must do only while the block
//   is idle; the block does not enforce it. A tick update runs eleven serial
//   multiplies (one multiplier bit per cycle, 8 to 33 bits each) and one
//   CORDIC pass of CORDIC_STEPS micro-rotations, capped at the arctangent
//   table length, spending almost all its time in the multiplier. For every
//   opcode the next word can be taken in the cycle after the result is loaded.
//   Set, reset and unused opcodes go straight from the accept to the load.
//   The result sits in an output register; the next word is accepted while it
//   waits, and a finished word holds in place until that register frees up.
//   Reset clears the pose, the last encoder counts and the registers to their
//   reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module diff_drive_odometry
#(
    parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  odo_pkg::odo_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output odo_pkg::odo_out_t                   out_data,
    input  logic                                cfg_wr_en,
    input  logic [odo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [odo_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_CORD = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Multiply steps of a tick update.
    localparam logic [3:0] STEP_HALF_DIFF = 4'd0;
    localparam logic [3:0] STEP_YAW_RATE  = 4'd1;
    localparam logic [3:0] STEP_YAW_TURN  = 4'd2;
    localparam logic [3:0] STEP_TRAVEL    = 4'd3;
    localparam logic [3:0] STEP_X         = 4'd4;
    localparam logic [3:0] STEP_Y         = 4'd5;
    localparam logic [3:0] STEP_TV_A      = 4'd6;
    localparam logic [3:0] STEP_TV_B      = 4'd7;
    localparam logic [3:0] STEP_RV_A      = 4'd8;
    localparam logic [3:0] STEP_RV_B      = 4'd9;
    localparam logic [3:0] STEP_RV_C      = 4'd10;

    localparam int AW = odo_pkg::MUL_A_W;
    localparam int BW = odo_pkg::MUL_B_W;
    localparam int NW = odo_pkg::MUL_N_W;

    logic [1:0]         state_reg;
    logic [3:0]         step_reg;
    logic               issued_reg;
    logic [31:0]        dpt_reg;
    logic [23:0]        iht_reg;
    logic [31:0]        x_reg;
    logic [31:0]        y_reg;
    logic [15:0]        yaw_reg;
    logic [15:0]        last_l_reg;
    logic [15:0]        last_r_reg;
    logic signed [15:0] dl_reg;
    logic signed [15:0] dr_reg;
    logic signed [15:0] ls_reg;
    logic signed [15:0] rs_reg;
    logic signed [AW-1:0] tmp_reg;
    logic signed [33:0] trav_reg;
    logic [31:0]        tv_reg;
    logic [31:0]        rv_reg;
    logic               out_valid_reg;
    odo_pkg::odo_out_t  out_reg;

    odo_pkg::odo_mul_ctl_t mul_ctl;
    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [AW-1:0]  mul_p;
    logic                  mul_done;
    logic                  cord_start;
    logic                  cord_done;
    logic signed [31:0]    cos_v;
    logic signed [31:0]    sin_v;
    logic signed [AW-1:0]  p_r16;
    logic signed [AW-1:0]  p_r17;
    logic signed [AW-1:0]  p_r30;
    logic signed [AW-1:0]  p_r48;
    logic                  accept;
    logic                  out_load;
    logic [15:0]           dl_new;
    logic [15:0]           dr_new;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign dl_new   = in_data.left_count - last_l_reg;
    assign dr_new   = in_data.right_count - last_r_reg;

    // Operand selection for the current multiply step.
    always_comb
    begin
        mul_ctl.start = (state_reg == ST_MUL) && !issued_reg;
        mul_ctl.nbits = NW'(BW);
        mul_a         = tmp_reg;
        mul_b         = $signed({1'b0, dpt_reg});
        unique case (step_reg)
            STEP_HALF_DIFF:
            begin
                mul_a = AW'($signed({dl_reg[15], dl_reg}) - $signed({dr_reg[15], dr_reg}));
            end
            STEP_YAW_RATE:
            begin
                mul_b         = $signed({9'b0, iht_reg});
                mul_ctl.nbits = NW'(25);
            end
            STEP_YAW_TURN:
            begin
                mul_b         = odo_pkg::RAD_TO_TURN;
                mul_ctl.nbits = NW'(31);
            end
            STEP_TRAVEL:
            begin
                mul_a = AW'($signed({dl_reg[15], dl_reg}) + $signed({dr_reg[15], dr_reg}));
            end
            STEP_X:
            begin
                mul_a         = AW'(trav_reg);
                mul_b         = BW'(cos_v);
                mul_ctl.nbits = NW'(32);
            end
            STEP_Y:
            begin
                mul_a         = AW'(trav_reg);
                mul_b         = BW'(sin_v);
                mul_ctl.nbits = NW'(32);
            end
            STEP_TV_A:
            begin
                mul_a = AW'($signed({ls_reg[15], ls_reg}) + $signed({rs_reg[15], rs_reg}));
            end
            STEP_RV_A:
            begin
                mul_a = AW'($signed({rs_reg[15], rs_reg}) - $signed({ls_reg[15], ls_reg}));
            end
            STEP_TV_B, STEP_RV_B:
            begin
                mul_b         = odo_pkg::VEL_SCALE;
                mul_ctl.nbits = NW'(8);
            end
            STEP_RV_C:
            begin
                mul_b         = $signed({9'b0, iht_reg});
                mul_ctl.nbits = NW'(25);
            end
            default:
            begin
                mul_a = tmp_reg;
            end
        endcase
    end

    // Rounded views of the product.
    always_comb
    begin
        p_r16 = odo_pkg::rnd_shift(mul_p, 16);
        p_r17 = odo_pkg::rnd_shift(mul_p, 17);
        p_r30 = odo_pkg::rnd_shift(mul_p, 30);
        p_r48 = odo_pkg::rnd_shift(mul_p, 48);
    end

    assign cord_start = (state_reg == ST_MUL) && mul_done && (step_reg == STEP_TRAVEL);

    odo_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_p),
        .done  (mul_done)
    );

    odo_cordic
    #(
        .STEPS (CORDIC_STEPS)
    )
    u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (yaw_reg),
        .cos_val (cos_v),
        .sin_val (sin_v),
        .done    (cord_done)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpt_reg <= '0;
            iht_reg <= odo_pkg::INV_HALF_TRACK_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                odo_pkg::REG_TICK_DIST:      dpt_reg <= cfg_data;
                odo_pkg::REG_INV_HALF_TRACK: iht_reg <= cfg_data[23:0];
                default:                     dpt_reg <= dpt_reg;
            endcase
        end
    end

    // Sequencer and pose state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= STEP_HALF_DIFF;
            issued_reg <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            yaw_reg    <= '0;
            last_l_reg <= '0;
            last_r_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        priority if (in_data.opcode == odo_pkg::OP_UPDATE)
                        begin
                            last_l_reg <= in_data.left_count;
                            last_r_reg <= in_data.right_count;
                            step_reg   <= STEP_HALF_DIFF;
                            issued_reg <= 1'b0;
                            state_reg  <= ST_MUL;
                        end
                        else if (in_data.opcode == odo_pkg::OP_SET)
                        begin
                            x_reg      <= in_data.new_x;
                            y_reg      <= in_data.new_y;
                            yaw_reg    <= in_data.new_yaw;
                            last_l_reg <= '0;
                            last_r_reg <= '0;
                            state_reg  <= ST_DONE;
                        end
                        else if (in_data.opcode == odo_pkg::OP_RESET)
                        begin
                            x_reg      <= '0;
                            y_reg      <= '0;
                            yaw_reg    <= '0;
                            last_l_reg <= '0;
                            last_r_reg <= '0;
                            state_reg  <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (mul_ctl.start)
                    begin
                        issued_reg <= 1'b1;
                    end
                    if (mul_done)
                    begin
                        issued_reg <= 1'b0;
                        step_reg   <= step_reg + 4'd1;
                        unique case (step_reg)
                            STEP_YAW_TURN: yaw_reg   <= yaw_reg - p_r48[15:0];
                            STEP_TRAVEL:   state_reg <= ST_CORD;
                            STEP_X:        x_reg     <= x_reg + p_r30[31:0];
                            STEP_Y:        y_reg     <= y_reg + p_r30[31:0];
                            STEP_RV_C:     state_reg <= ST_DONE;
                            default:       state_reg <= ST_MUL;
                        endcase
                    end
                end
                ST_CORD:
                begin
                    if (cord_done)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working payload: deltas, intermediate products and velocities.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dl_reg <= dl_new;
            dr_reg <= dr_new;
            ls_reg <= in_data.left_rate;
            rs_reg <= in_data.right_rate;
            tv_reg <= '0;
            rv_reg <= '0;
        end
        if ((state_reg == ST_MUL) && mul_done)
        begin
            unique case (step_reg)
                STEP_HALF_DIFF: tmp_reg  <= p_r17;
                STEP_TRAVEL:    trav_reg <= p_r17[33:0];
                STEP_TV_B:      tv_reg   <= odo_pkg::sat32(p_r17);
                STEP_RV_B:      tmp_reg  <= p_r17;
                STEP_RV_C:      rv_reg   <= odo_pkg::sat32(p_r16);
                default:        tmp_reg  <= mul_p;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.pos_x   <= x_reg;
            out_reg.pos_y   <= y_reg;
            out_reg.heading <= yaw_reg;
            out_reg.lin_vel <= tv_reg;
            out_reg.rot_vel <= rv_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> src/odo_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry port checker
// Watches the ports of the odometry block for handshake and pose rules.
// ----------------------------------------------------------------------------
module odo_chk
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input odo_pkg::odo_in_t               in_data,
    input logic                           out_valid,
    input logic                           out_ready,
    input odo_pkg::odo_out_t              out_data
);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // One word at a time: ready drops after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // Reset pose yields a zero pose and zero velocities in the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && (in_data.opcode == odo_pkg::OP_RESET)
        |=> ##1 out_valid && (out_data.pos_x == 0) && (out_data.pos_y == 0)
            && (out_data.heading == 0) && (out_data.lin_vel == 0)
            && (out_data.rot_vel == 0))
        else $error("reset pose result wrong");

    // Set pose x and heading are echoed in the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && (in_data.opcode == odo_pkg::OP_SET)
        |=> ##1 out_valid && (out_data.pos_x == $past(in_data.new_x, 2))
            && (out_data.heading == $past(in_data.new_yaw, 2)))
        else $error("set pose result wrong");

endmodule

bind diff_drive_odometry odo_chk u_odo_chk (.*);
